@@ hw/rtl/i2c_display_write_framer_top_defines.svh @@
// Assertion macros used by the framer's checker file.
`ifndef I2C_DISPLAY_WRITE_FRAMER_TOP_DEFINES_SVH
`define I2C_DISPLAY_WRITE_FRAMER_TOP_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define I2CDWF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define I2CDWF_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/i2cdwf_pkg.sv @@
// Types and constants shared by the I2C display write framer modules.
`timescale 1ns / 1ps
package i2cdwf_pkg;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;
  localparam logic [CfgIdxW-1:0] CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_COMMAND_PREFIX = 1'b1;

  // Register reset values.
  localparam logic [6:0] DEVICE_ADDRESS_RST = 7'd60;
  localparam logic [7:0] COMMAND_PREFIX_RST = 8'h00;

  // Control byte that opens a data run.
  localparam logic [7:0] DATA_RUN_CONTROL = 8'h40;

  // Bit counter: eight data bits, then the ack slot.
  localparam logic [3:0] ACK_SLOT = 4'd8;

  // Depth of the job queue between front and back.
  localparam logic [1:0] JOB_FIFO_DEPTH = 2'd2;

  typedef enum logic [1:0] {
    ACT_COMMAND   = 2'd0,
    ACT_DATA_OPEN = 2'd1,
    ACT_DATA_BYTE = 2'd2,
    ACT_STOP      = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    SYM_START = 2'd0,
    SYM_BIT   = 2'd1,
    SYM_ACK   = 2'd2,
    SYM_STOP  = 2'd3
  } sym_kind_e;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_BYTE  = 2'd1,
    PH_STOP  = 2'd2
  } phase_e;

  // One classified bus job: optional start, up to three bytes, optional stop.
  typedef struct packed {
    logic            has_start;
    logic            has_stop;
    logic [1:0]      num_bytes;
    logic [2:0][7:0] bytes;
  } job_t;

endpackage

@@ hw/rtl/i2cdwf_job_fifo.sv @@
// Two-entry job queue between the classifying front end and the symbol sequencer.
`timescale 1ns / 1ps
module i2cdwf_job_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  i2cdwf_pkg::job_t   push_job_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output i2cdwf_pkg::job_t   pop_job_o
);
  import i2cdwf_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  // Handshake on both ends.
  assign push_ready_o = (count_q != JOB_FIFO_DEPTH);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

@@ hw/rtl/i2cdwf_front.sv @@
// Front end: holds the configuration registers and turns each action into a bus job.
`timescale 1ns / 1ps
module i2cdwf_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [i2cdwf_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [i2cdwf_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          in_action_i,
  input  logic [7:0]                          in_value_i,
  output logic                                job_valid_o,
  input  logic                                job_ready_i,
  output i2cdwf_pkg::job_t                    job_o
);
  import i2cdwf_pkg::*;

  logic [6:0] device_address_q;
  logic [7:0] command_prefix_q;
  logic [7:0] addr_byte;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_address_q <= DEVICE_ADDRESS_RST;
      command_prefix_q <= COMMAND_PREFIX_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DEVICE_ADDRESS: device_address_q <= cfg_wdata_i[6:0];
        CFG_COMMAND_PREFIX: command_prefix_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The address goes out shifted left with the write bit low.
  assign addr_byte = {device_address_q, 1'b0};

  // Classify the action into start, byte list and stop.
  always_comb begin
    job_o = '0;
    case (action_e'(in_action_i))
      ACT_COMMAND: begin
        job_o.has_start = 1'b1;
        job_o.has_stop  = 1'b1;
        job_o.num_bytes = 2'd3;
        job_o.bytes[0]  = addr_byte;
        job_o.bytes[1]  = command_prefix_q;
        job_o.bytes[2]  = in_value_i;
      end
      ACT_DATA_OPEN: begin
        job_o.has_start = 1'b1;
        job_o.num_bytes = 2'd2;
        job_o.bytes[0]  = addr_byte;
        job_o.bytes[1]  = DATA_RUN_CONTROL;
      end
      ACT_DATA_BYTE: begin
        job_o.num_bytes = 2'd1;
        job_o.bytes[0]  = in_value_i;
      end
      default: begin
        job_o.has_stop = 1'b1;
      end
    endcase
  end

  assign job_valid_o = in_valid_i;
  assign in_ready_o  = job_ready_i;

endmodule

@@ hw/rtl/i2cdwf_back.sv @@
// Back end: walks a queued job one bus symbol per cycle, unless the output stalls, into the output register.
`timescale 1ns / 1ps
module i2cdwf_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  output logic                   job_ready_o,
  input  i2cdwf_pkg::job_t       job_i,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output logic [1:0]             m_kind_o,
  output logic                   m_level_o,
  output logic                   m_last_o
);
  import i2cdwf_pkg::*;

  phase_e     phase_q, phase_d, eff_phase;
  logic [1:0] byte_q, byte_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] cur_byte;
  sym_kind_e  sym_kind;
  logic       sym_level, sym_last, emit;
  logic       m_valid_q, m_level_q, m_last_q;
  sym_kind_e  m_kind_q;

  // A new symbol goes out when a job waits and the output register is free.
  assign emit        = job_valid_i && (!m_valid_q || m_ready_i);
  assign job_ready_o = emit && sym_last;

  // Current symbol and next position within the job.
  always_comb begin
    eff_phase = phase_q;
    if (eff_phase == PH_START && !job_i.has_start) begin
      eff_phase = PH_BYTE;
    end
    if (eff_phase == PH_BYTE && byte_q == job_i.num_bytes) begin
      eff_phase = PH_STOP;
    end

    case (byte_q)
      2'd0:    cur_byte = job_i.bytes[0];
      2'd1:    cur_byte = job_i.bytes[1];
      default: cur_byte = job_i.bytes[2];
    endcase

    sym_kind  = SYM_START;
    sym_level = 1'b0;
    sym_last  = 1'b0;
    case (eff_phase)
      PH_BYTE: begin
        if (bit_q == ACK_SLOT) begin
          sym_kind  = SYM_ACK;
          sym_level = 1'b1;
          sym_last  = (byte_q == 2'(job_i.num_bytes - 2'd1)) && !job_i.has_stop;
        end else begin
          // Most significant bit first.
          sym_kind  = SYM_BIT;
          sym_level = cur_byte[~bit_q[2:0]];
        end
      end
      PH_STOP: begin
        sym_kind = SYM_STOP;
        sym_last = 1'b1;
      end
      default: ;
    endcase

    phase_d = phase_q;
    byte_d  = byte_q;
    bit_d   = bit_q;
    if (emit) begin
      if (sym_last) begin
        phase_d = PH_START;
        byte_d  = 2'd0;
        bit_d   = 4'd0;
      end else begin
        case (eff_phase)
          PH_START: begin
            phase_d = PH_BYTE;
            byte_d  = 2'd0;
            bit_d   = 4'd0;
          end
          PH_BYTE: begin
            phase_d = PH_BYTE;
            if (bit_q == ACK_SLOT) begin
              byte_d = byte_q + 2'd1;
              bit_d  = 4'd0;
            end else begin
              bit_d = bit_q + 4'd1;
            end
          end
          default: phase_d = PH_START;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      byte_q  <= 2'd0;
      bit_q   <= 4'd0;
    end else begin
      phase_q <= phase_d;
      byte_q  <= byte_d;
      bit_q   <= bit_d;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit) begin
      m_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      m_kind_q  <= sym_kind;
      m_level_q <= sym_level;
      m_last_q  <= sym_last;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_kind_o  = m_kind_q;
  assign m_level_o = m_level_q;
  assign m_last_o  = m_last_q;

endmodule

@@ hw/rtl/i2c_display_write_framer_top.sv @@
// The first symbol of an item passes through the job queue, then the output register.
// The back-end sequencer and output register send one symbol per cycle unless stalled:
// a command item gives 29 symbols, a data-run open 19, a data byte 9, a stop 1.
// A two-entry job queue lets new items be accepted while earlier ones are still sent.
// Reset is asynchronous, active low: queue and output empty, address 60, prefix 0x00.
`timescale 1ns / 1ps
module i2c_display_write_framer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [i2cdwf_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [i2cdwf_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [7:0] value
  input  logic [1:0]                        s_axis_tuser,  // [1:0] action
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [7:0]                        m_axis_tdata,  // [0] data_level, [7:1] zero
  output logic [1:0]                        m_axis_tuser,  // [1:0] symbol_kind
  output logic                              m_axis_tlast   // run_last
);
  import i2cdwf_pkg::*;

  logic fe_valid, fe_ready, be_valid, be_ready, m_level;
  job_t fe_job, be_job;

  // Front end: configuration and classification.
  i2cdwf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_value_i  (s_axis_tdata),
    .job_valid_o (fe_valid),
    .job_ready_i (fe_ready),
    .job_o       (fe_job)
  );

  // Job queue.
  i2cdwf_job_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_job_i   (fe_job),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_job_o    (be_job)
  );

  // Back end: symbol sequencer.
  i2cdwf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (be_valid),
    .job_ready_o (be_ready),
    .job_i       (be_job),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_kind_o    (m_axis_tuser),
    .m_level_o   (m_level),
    .m_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, m_level};

endmodule

@@ hw/rtl/i2cdwf_checker.sv @@
// Port-level checker for the framer and the bind that attaches it.
`timescale 1ns / 1ps
`include "i2c_display_write_framer_top_defines.svh"
module i2cdwf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);
  import i2cdwf_pkg::*;

  // No transaction is offered while in reset.
  `I2CDWF_ASSERT_RST(a_no_valid_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid, "output valid in reset")

  // A stalled output transaction holds its payload.
  `I2CDWF_ASSERT(a_stall_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled output changed")

  // Start and stop drive level zero; an ack slot is released high.
  `I2CDWF_ASSERT(a_level_by_kind, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tdata[7:1] == 7'd0) && ((m_axis_tuser == SYM_START || m_axis_tuser == SYM_STOP) ? !m_axis_tdata[0] : ((m_axis_tuser == SYM_ACK) ? m_axis_tdata[0] : 1'b1)), "bad level for symbol kind")

  // A stop always ends a run, a start or a data bit never does.
  `I2CDWF_ASSERT(a_last_by_kind, clk_i, rst_ni, m_axis_tvalid |-> ((m_axis_tuser == SYM_STOP) ? m_axis_tlast : ((m_axis_tuser == SYM_START || m_axis_tuser == SYM_BIT) ? !m_axis_tlast : 1'b1)), "bad last flag for symbol kind")

endmodule

bind i2c_display_write_framer_top i2cdwf_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
